@@ src/gwwm_pkg.sv @@
`timescale 1ns / 1ps

package gwwm_pkg;

  // Glyph advance table geometry.
  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_AW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // Character codes with special meaning.
  localparam logic [7:0] CH_NULL     = 8'd0;
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_FIRST    = 8'd33;
  localparam logic [7:0] CH_LAST     = 8'd127;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_BACKTICK = 8'd96;

  // Layout constants.
  localparam logic [2:0] WORD_GAP   = 3'd5;
  localparam logic [1:0] LINE_EXTRA = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  FONT_H_RST      = 8'd8;
  localparam logic [15:0] LINE_WIDTH_RST  = 16'd320;
  localparam logic [5:0]  SPACE_WIDTH_RST = 6'd6;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_BOX  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_FONT_H      = 2'd0,
    REG_LINE_WIDTH  = 2'd1,
    REG_SPACE_WIDTH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  font_h;
    logic [15:0] line_width;
    logic [5:0]  space_width;
  } cfg_t;

  // Character item held between the table read and the layout stage.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       use_table;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] extent_w;
    logic [15:0] extent_h;
    logic        final_res;
  } res_t;

  // Clamp an unsigned sum to 16 bits.
  function automatic logic [15:0] sat16(input logic [17:0] v);
    return (|v[17:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

@@ src/gwwm_ifs.sv @@
`timescale 1ns / 1ps

// Character and table-load items.
interface gwwm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] code;
  logic [5:0] glyph_advance;
  logic       end_of_text;

  modport source (output valid, op, code, glyph_advance, end_of_text, input ready);
  modport sink   (input valid, op, code, glyph_advance, end_of_text, output ready);
endinterface

// Word placements and box sizes.
interface gwwm_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] extent_w;
  logic [15:0] extent_h;
  logic        final_res;

  modport source (output valid, kind, pos_x, pos_y, extent_w, extent_h, final_res,
                  input ready);
  modport sink   (input valid, kind, pos_x, pos_y, extent_w, extent_h, final_res,
                  output ready);
endinterface

// Register writes.
interface gwwm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/greedy_word_wrap_measure.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Transfer carries
// in_ch     sink       op, code, glyph_advance, end_of_text
// out_ch    source     kind, pos_x, pos_y, extent_w, extent_h, final_res
// cfg_ch    sink       index (0 font height, 1 line_width, 2 space_width), data
//
// One input item per cycle. A character sits in an input register during its table
// read, and its results enter the result queue when the layout stage takes it, which
// waits for queue room. A character that ends a text can yield two results;
// the input stalls while fewer than two of the four queue entries are free.
// Synchronous reset clears the text state, the queue and the registers to their
// defaults; the glyph table keeps its contents and is undefined until loaded.

module greedy_word_wrap_measure import gwwm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gwwm_in_if.sink    in_ch,
  gwwm_out_if.source out_ch,
  gwwm_cfg_if.sink   cfg_ch
);

  cfg_t                cfg_r;
  logic                a_valid_r, a_valid_nxt;
  item_t               a_item_r, a_item_nxt;
  logic                in_acc, take, room;
  logic                tbl_wr, tbl_rd;
  logic [7:0]          glyph_idx;
  logic [5:0]          tbl_data;
  logic [1:0]          push_cnt;
  res_t                res0, res1, head_res;
  logic                q_valid;

  // Register writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_h      <= FONT_H_RST;
      cfg_r.line_width  <= LINE_WIDTH_RST;
      cfg_r.space_width <= SPACE_WIDTH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_FONT_H:      cfg_r.font_h      <= cfg_ch.data[7:0];
        REG_LINE_WIDTH:  cfg_r.line_width  <= cfg_ch.data;
        REG_SPACE_WIDTH: cfg_r.space_width <= cfg_ch.data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Input transfer, table access and the character stage register.
  always_comb begin
    take         = a_valid_r && room;
    in_ch.ready  = !a_valid_r || take;
    in_acc       = in_ch.valid && in_ch.ready;
    glyph_idx    = in_ch.code - CH_FIRST;
    tbl_wr       = in_acc && (in_ch.op == OP_LOAD) &&
                   ({1'b0, in_ch.code} < 9'(GLYPH_COUNT));
    tbl_rd       = in_acc && (in_ch.op == OP_CHAR);

    a_item_nxt.code      = in_ch.code;
    a_item_nxt.last      = in_ch.end_of_text;
    a_item_nxt.use_table = (in_ch.code >= CH_FIRST) && (in_ch.code <= CH_LAST) &&
                           ({1'b0, glyph_idx} < 9'(GLYPH_COUNT));
    a_valid_nxt          = tbl_rd || (a_valid_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_rd) begin
      a_item_r <= a_item_nxt;
    end
  end

  gwwm_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_ch.code[GLYPH_AW-1:0]),
    .wr_data (in_ch.glyph_advance),
    .rd_en   (tbl_rd),
    .rd_addr (glyph_idx[GLYPH_AW-1:0]),
    .rd_data (tbl_data)
  );

  gwwm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (a_item_r),
    .table_adv (tbl_data),
    .cfg       (cfg_r),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  gwwm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (q_valid),
    .out_ready (out_ch.ready),
    .out_res   (head_res)
  );

  // Result channel.
  assign out_ch.valid     = q_valid;
  assign out_ch.kind      = head_res.kind;
  assign out_ch.pos_x     = head_res.pos_x;
  assign out_ch.pos_y     = head_res.pos_y;
  assign out_ch.extent_w  = head_res.extent_w;
  assign out_ch.extent_h  = head_res.extent_h;
  assign out_ch.final_res = head_res.final_res;

endmodule

@@ src/gwwm_table.sv @@
`timescale 1ns / 1ps

module gwwm_table import gwwm_pkg::*; (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [GLYPH_AW-1:0] wr_addr,
  input  logic [5:0]          wr_data,
  input  logic                rd_en,
  input  logic [GLYPH_AW-1:0] rd_addr,
  output logic [5:0]          rd_data
);

  logic [5:0] mem [GLYPH_COUNT];
  logic [5:0] rd_data_r;

  // Glyph advance storage, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/gwwm_core.sv @@
`timescale 1ns / 1ps

module gwwm_core import gwwm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  item_t      item,
  input  logic [5:0] table_adv,
  input  cfg_t       cfg,
  output logic [1:0] push_cnt,
  output res_t       res0,
  output res_t       res1
);

  logic [15:0] word_r, word_nxt;
  logic        in_word_r, in_word_nxt;
  logic [15:0] pen_x_r, pen_x_nxt;
  logic [15:0] pen_y_r, pen_y_nxt;
  logic [15:0] widest_r, widest_nxt;

  logic        is_nl, is_delim, is_normal;
  logic [5:0]  char_w;
  logic [15:0] word_w;
  logic        word_open, do_fin, wrap;
  logic [8:0]  step;
  logic [9:0]  y_off;
  logic [15:0] py0, px0, pen_x_fin, box_h;
  logic        px_zero;
  res_t        word_res, box_res;

  // Character classification and width of the incoming character.
  always_comb begin
    is_nl     = (item.code == CH_NEWLINE);
    is_delim  = is_nl || (item.code == CH_SPACE);
    is_normal = !is_delim && (item.code != CH_NULL);
    if ((item.code == CH_DOLLAR) || (item.code == CH_BACKTICK)) begin
      char_w = 6'd0;
    end else if (item.use_table) begin
      char_w = table_adv;
    end else begin
      char_w = cfg.space_width;
    end
  end

  // Word closing, wrap decision and pen movement.
  always_comb begin
    word_w    = is_normal ? sat16(18'(word_r) + 18'(char_w)) : word_r;
    word_open = is_normal || in_word_r;
    do_fin    = word_open && (is_delim || item.last);
    wrap      = do_fin && ((17'(word_w) + 17'(pen_x_r)) > 17'(cfg.line_width));
    step      = 9'(cfg.font_h) + 9'(LINE_EXTRA) + 9'd1;
    y_off     = (wrap ? 10'(step) : 10'd0) + (is_nl ? 10'(step) : 10'd0);
    py0       = wrap ? sat16(18'(pen_y_r) + 18'(step)) : pen_y_r;
    px0       = wrap ? 16'd0 : pen_x_r;
    pen_x_fin = sat16(18'(px0) + 18'(word_w) + 18'(WORD_GAP));
    pen_y_nxt = sat16(18'(pen_y_r) + 18'(y_off));

    if (is_nl) begin
      pen_x_nxt = 16'd0;
    end else if (do_fin) begin
      pen_x_nxt = pen_x_fin;
    end else begin
      pen_x_nxt = pen_x_r;
    end

    widest_nxt = (do_fin && (pen_x_fin > widest_r)) ? pen_x_fin : widest_r;

    // A closed word always leaves the pen past the gap, so x is zero only here.
    px_zero = is_nl || (!do_fin && (pen_x_r == 16'd0));
    box_h   = px_zero ? pen_y_nxt
                      : sat16(18'(pen_y_r) + 18'(y_off) + 18'(cfg.font_h) +
                              18'(LINE_EXTRA));

    word_nxt    = do_fin ? 16'd0 : word_w;
    in_word_nxt = do_fin ? 1'b0 : word_open;
  end

  // Result items.
  always_comb begin
    word_res.kind      = KIND_WORD;
    word_res.pos_x     = px0;
    word_res.pos_y     = py0;
    word_res.extent_w  = word_w;
    word_res.extent_h  = 16'd0;
    word_res.final_res = !item.last;

    box_res.kind      = KIND_BOX;
    box_res.pos_x     = 16'd0;
    box_res.pos_y     = 16'd0;
    box_res.extent_w  = widest_nxt;
    box_res.extent_h  = box_h;
    box_res.final_res = 1'b1;

    res0     = do_fin ? word_res : box_res;
    res1     = box_res;
    push_cnt = take ? (2'(do_fin) + 2'(item.last)) : 2'd0;
  end

  // Text state; the end of a text clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r    <= 16'd0;
      in_word_r <= 1'b0;
      pen_x_r   <= 16'd0;
      pen_y_r   <= 16'd0;
      widest_r  <= 16'd0;
    end else if (take) begin
      if (item.last) begin
        word_r    <= 16'd0;
        in_word_r <= 1'b0;
        pen_x_r   <= 16'd0;
        pen_y_r   <= 16'd0;
        widest_r  <= 16'd0;
      end else begin
        word_r    <= word_nxt;
        in_word_r <= in_word_nxt;
        pen_x_r   <= pen_x_nxt;
        pen_y_r   <= pen_y_nxt;
        widest_r  <= widest_nxt;
      end
    end
  end

endmodule

@@ src/gwwm_outq.sv @@
`timescale 1ns / 1ps

module gwwm_outq import gwwm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  res_t       res0,
  input  res_t       res1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  res_t             q_r [QDEPTH];
  logic [QAW-1:0]   head_r, head_nxt;
  logic [QAW-1:0]   tail_r, tail_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             pop;

  // Occupancy and pointer updates.
  always_comb begin
    out_valid = (cnt_r != '0);
    out_res   = q_r[head_r];
    pop       = out_valid && out_ready;
    room      = (cnt_r <= (QAW+1)'(QDEPTH - 2));
    head_nxt  = head_r + QAW'(pop);
    tail_nxt  = tail_r + QAW'(push_cnt);
    cnt_nxt   = cnt_r + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage; a second result goes in right behind the first.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[tail_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      q_r[tail_r + QAW'(1)] <= res1;
    end
  end

endmodule

@@ verif/gwwm_tb_pkg.sv @@
`timescale 1ns / 1ps

package gwwm_tb_pkg;
  import gwwm_pkg::*;

  // Tracks the layout state of the wrap engine and holds the placements and
  // box sizes that the accepted characters must produce, oldest first.
  class layout_scoreboard;
    logic [5:0]  glyph_adv [GLYPH_COUNT];
    int unsigned word_w;
    bit          in_word;
    int unsigned pen_x;
    int unsigned pen_y;
    int unsigned widest;
    int unsigned line_h;
    int unsigned line_w;
    int unsigned space_w;
    res_t        expected_layouts[$];
    int unsigned errors;

    function new();
      foreach (glyph_adv[i]) glyph_adv[i] = '0;
      line_h  = FONT_H_RST;
      line_w  = LINE_WIDTH_RST;
      space_w = SPACE_WIDTH_RST;
      errors  = 0;
      clear_text();
    endfunction

    function void clear_text();
      word_w  = 0;
      in_word = 1'b0;
      pen_x   = 0;
      pen_y   = 0;
      widest  = 0;
    endfunction

    function int unsigned clamp16(int unsigned v);
      return (v > 65535) ? 65535 : v;
    endfunction

    function int unsigned outstanding();
      return expected_layouts.size();
    endfunction

    // Mirror of a register write that the block accepted.
    function void set_reg(cfg_reg_e idx, logic [15:0] data);
      case (idx)
        REG_FONT_H:      line_h  = data[7:0];
        REG_LINE_WIDTH:  line_w  = data;
        REG_SPACE_WIDTH: space_w = data[5:0];
        default: ;
      endcase
    endfunction

    // Advance of one character inside a word.
    function int unsigned glyph_width(logic [7:0] code);
      if (code == CH_DOLLAR || code == CH_BACKTICK) return 0;
      if (code >= CH_FIRST && code <= CH_LAST && int'(code - CH_FIRST) < GLYPH_COUNT)
        return glyph_adv[int'(code - CH_FIRST)];
      return space_w;
    endfunction

    // Close the open word: wrap if it does not fit, then record its placement.
    function void place_word();
      res_t r;
      if (word_w + pen_x > line_w) begin
        pen_y = clamp16(pen_y + line_h + LINE_EXTRA + 1);
        pen_x = 0;
      end
      r.kind      = KIND_WORD;
      r.pos_x     = 16'(pen_x);
      r.pos_y     = 16'(pen_y);
      r.extent_w  = 16'(word_w);
      r.extent_h  = '0;
      r.final_res = 1'b0;
      expected_layouts.push_back(r);
      pen_x = clamp16(pen_x + word_w + WORD_GAP);
      if (pen_x > widest) widest = pen_x;
      word_w  = 0;
      in_word = 1'b0;
    endfunction

    // Called for every accepted input transfer.
    function void note_item(op_e op, logic [7:0] code, logic [5:0] adv, logic eot);
      int   n_before;
      res_t box;
      n_before = expected_layouts.size();
      if (op == OP_LOAD) begin
        if (code < GLYPH_COUNT) glyph_adv[code] = adv;
        return;
      end
      if (code == CH_SPACE) begin
        if (in_word) place_word();
      end else if (code == CH_NEWLINE) begin
        if (in_word) place_word();
        pen_y = clamp16(pen_y + line_h + LINE_EXTRA + 1);
        pen_x = 0;
      end else if (code != CH_NULL) begin
        word_w  = clamp16(word_w + glyph_width(code));
        in_word = 1'b1;
      end
      // The end mark flushes the open word and reports the box.
      if (eot) begin
        if (in_word) place_word();
        box.kind      = KIND_BOX;
        box.pos_x     = '0;
        box.pos_y     = '0;
        box.extent_w  = 16'(widest);
        box.extent_h  = 16'((pen_x == 0) ? pen_y : clamp16(pen_y + line_h + LINE_EXTRA));
        box.final_res = 1'b0;
        expected_layouts.push_back(box);
        clear_text();
      end
      if (expected_layouts.size() > n_before)
        expected_layouts[expected_layouts.size() - 1].final_res = 1'b1;
    endfunction

    // Called for every accepted result transfer.
    function void check_result(res_t got);
      res_t want;
      if (expected_layouts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result kind %s x %0d y %0d w %0d h %0d last %0b",
                   $time, got.kind.name(), got.pos_x, got.pos_y, got.extent_w,
                   got.extent_h, got.final_res);
        return;
      end
      want = expected_layouts.pop_front();
      if (got.kind !== want.kind || got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.extent_w !== want.extent_w || got.extent_h !== want.extent_h ||
          got.final_res !== want.final_res) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected kind %s x %0d y %0d w %0d h %0d last %0b",
                   want.kind.name(), want.pos_x, want.pos_y, want.extent_w,
                   want.extent_h, want.final_res);
          $display("  actual   kind %s x %0d y %0d w %0d h %0d last %0b",
                   got.kind.name(), got.pos_x, got.pos_y, got.extent_w,
                   got.extent_h, got.final_res);
        end
      end
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import gwwm_pkg::*;
  import gwwm_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;

  gwwm_in_if  in_if ();
  gwwm_out_if out_if ();
  gwwm_cfg_if cfg_if ();

  greedy_word_wrap_measure dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  layout_scoreboard sb;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result ready: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind      = kind_e'(out_if.kind);
      got.pos_x     = out_if.pos_x;
      got.pos_y     = out_if.pos_y;
      got.extent_w  = out_if.extent_w;
      got.extent_h  = out_if.extent_h;
      got.final_res = out_if.final_res;
      sb.check_result(got);
    end
  end

  // Offers one item after a random gap and returns at the falling edge after its
  // transfer. Valid stays high so that a following item goes out back to back.
  task automatic send_item(op_e op, logic [7:0] code, logic [5:0] adv, logic eot);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.op            = op;
    in_if.code          = code;
    in_if.glyph_advance = adv;
    in_if.end_of_text   = eot;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(op, code, adv, eot);
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] code, logic eot);
    send_item(OP_CHAR, code, 6'($urandom_range(63)), eot);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Stop offering, wait for every expected result, then let the pipeline empty.
  task automatic settle();
    in_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_word_char();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(99);
    if (r < 80) begin
      c = 8'($urandom_range(33, 127));
    end else if (r < 90) begin
      c = 8'($urandom_range(128, 255));
    end else begin
      c = 8'($urandom_range(1, 31));
      if (c == CH_NEWLINE) c = 8'd11;
    end
    return c;
  endfunction

  task automatic run_directed();
    logic [5:0] adv;
    // Load the whole table first so no character reads an unwritten entry.
    for (int g = 0; g < GLYPH_COUNT; g++) begin
      if (g % 31 == 0) adv = 6'd63;
      else if (g == 5) adv = 6'd0;
      else adv = 6'($urandom_range(2, 12));
      send_item(OP_LOAD, 8'(g), adv, 1'b0);
    end
    // Loads beyond the table are dropped, with or without an end mark.
    send_item(OP_LOAD, 8'd95, 6'd63, 1'b0);
    send_item(OP_LOAD, 8'd255, 6'd42, 1'b1);
    // Null byte, then a word mixing table, zero-width and blank-width codes.
    send_char(CH_NULL, 1'b0);
    send_char(8'd72, 1'b0);
    send_char(CH_DOLLAR, 1'b0);
    send_char(CH_BACKTICK, 1'b0);
    send_char(CH_LAST, 1'b0);
    send_char(CH_FIRST, 1'b0);
    send_char(8'd9, 1'b0);
    send_char(8'd200, 1'b0);
    send_char(8'd1, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_SPACE, 1'b0);
    // A zero-width word is still placed.
    send_char(CH_DOLLAR, 1'b0);
    send_char(CH_BACKTICK, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_NEWLINE, 1'b0);
    send_char(CH_NEWLINE, 1'b0);
    // End marks on a word character, a null byte, a space and a newline.
    send_char(8'd97, 1'b1);
    send_char(CH_NULL, 1'b1);
    send_char(8'd98, 1'b0);
    send_char(CH_SPACE, 1'b1);
    send_char(8'd99, 1'b0);
    send_char(CH_NEWLINE, 1'b1);
    settle();
    // With no line width every word wraps, even at line start.
    write_reg(REG_LINE_WIDTH, 16'd0);
    send_char(8'd120, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_DOLLAR, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_BACKTICK, 1'b0);
    send_char(CH_SPACE, 1'b1);
  endtask

  // One well-formed text of a few words ending in an end mark.
  task automatic send_text(inout int unsigned sent);
    int unsigned words;
    int unsigned len;
    int unsigned r;
    bit          end_on_char;
    bit          eot;
    words       = $urandom_range(1, 6);
    end_on_char = $urandom_range(1);
    for (int w = 0; w < words; w++) begin
      len = $urandom_range(1, 8);
      for (int c = 0; c < len; c++) begin
        eot = (w == words - 1) && (c == len - 1) && end_on_char;
        send_char(pick_word_char(), eot);
        sent++;
      end
      if (w != words - 1 || !end_on_char) begin
        eot = (w == words - 1);
        r = $urandom_range(99);
        if (r < 70) begin
          send_char(CH_SPACE, eot);
        end else if (r < 88) begin
          send_char(CH_NEWLINE, eot);
        end else if (r < 95) begin
          send_char(CH_SPACE, 1'b0);
          send_char(CH_SPACE, eot);
        end else begin
          send_char(CH_NULL, eot);
        end
        sent++;
      end
    end
  endtask

  // Mostly whole texts, with table reloads and raw bytes mixed in.
  task automatic run_random(int unsigned n);
    int unsigned sent;
    logic [7:0]  code;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 10) begin
        code = 8'($urandom_range(255));
        if ($urandom_range(1)) begin
          send_item(OP_LOAD, code, 6'($urandom_range(63)), 1'($urandom_range(1)));
          if (code < GLYPH_COUNT) sent++;
        end else begin
          send_char(code, ($urandom_range(9) == 0));
          if (code != CH_NULL) sent++;
        end
      end else begin
        send_text(sent);
      end
    end
  endtask

  // Drive the pen y position and the box height into saturation.
  task automatic run_saturation();
    write_reg(REG_FONT_H, 16'd255);
    write_reg(REG_LINE_WIDTH, 16'hFFFF);
    write_reg(REG_SPACE_WIDTH, 16'd63);
    repeat (257) send_char(CH_NEWLINE, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(CH_NULL, 1'b1);
  endtask

  // Main sequence.
  initial begin
    logic [15:0] lw;
    sb = new();
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.op            = 1'b0;
    in_if.code          = '0;
    in_if.glyph_advance = '0;
    in_if.end_of_text   = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    tx_idle_pct = 35;
    rx_idle_pct = 88;
    run_directed();

    // Random phases, each under its own idle rates, and runs within each under their own register settings.
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 88;
        end
        1: begin
          tx_idle_pct = 88;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 5; p++) begin
        settle();
        lw = 16'($urandom_range(16, 400));
        if (m == 1 && p == 4) lw = 16'hFFFF;
        write_reg(REG_LINE_WIDTH, lw);
        case (p)
          0: begin
            write_reg(REG_FONT_H, 16'd1);
            write_reg(REG_SPACE_WIDTH, 16'd0);
          end
          1: begin
            write_reg(REG_FONT_H, 16'd255);
            write_reg(REG_SPACE_WIDTH, 16'd63);
          end
          default: begin
            write_reg(REG_FONT_H, 16'($urandom_range(1, 255)));
            write_reg(REG_SPACE_WIDTH, 16'($urandom_range(0, 63)));
          end
        endcase
        // Hold the result side off long enough for the block to back up.
        if (m == 0 && p == 2) hold_cycles = 300;
        run_random(60);
      end
    end

    settle();
    run_saturation();
    settle();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
